### hdl/pool_linked_list_engine_defines.svh
// pool_linked_list_engine_defines.svh: assertion macros for the linked list engine
// expects signals clk and rst_n in the module that uses them
`ifndef POOL_LINKED_LIST_ENGINE_DEFINES_SVH
`define POOL_LINKED_LIST_ENGINE_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define PLLE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked in the same cycle
`define PLLE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

### hdl/plle_pkg.sv
// plle_pkg.sv: types and constants of the pool linked list engine
// used by the channel interfaces and the top level, depends on nothing

package plle_pkg;

  // default configuration
  localparam int POOL_SLOTS_DEF = 32;
  localparam int DATA_WIDTH_DEF = 32;

  // fixed channel field widths
  localparam int MODE_W     = 2;
  localparam int ID_W       = 16;
  localparam int DATA_IN_W  = 32;
  localparam int STATUS_W   = 3;
  localparam int SLOT_OUT_W = 5;
  localparam int FDATA_W    = 32;
  localparam int FCOUNT_W   = 6;

  // operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND = 2'd0,
    MODE_SEARCH = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_NOT_FOUND = 3'd2,
    STAT_DEL_HEAD  = 3'd3,
    STAT_DEL_TAIL  = 3'd4,
    STAT_DEL_MID   = 3'd5
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_WALK,
    S_FREE,
    S_DONE
  } state_t;

endpackage

### hdl/plle_ifs.sv
// plle_ifs.sv: valid/ready channel interfaces for operation and result items
// depends on plle_pkg for the field widths

interface plle_in_if;
  logic                           valid;
  logic                           ready;
  logic [plle_pkg::MODE_W-1:0]    mode;
  logic [plle_pkg::ID_W-1:0]      item_id;
  logic [plle_pkg::DATA_IN_W-1:0] item_data;

  modport source (output valid, mode, item_id, item_data, input ready);
  modport sink   (input valid, mode, item_id, item_data, output ready);
endinterface

interface plle_out_if;
  logic                            valid;
  logic                            ready;
  logic [plle_pkg::STATUS_W-1:0]   status;
  logic [plle_pkg::SLOT_OUT_W-1:0] found_slot;
  logic [plle_pkg::FDATA_W-1:0]    found_data;
  logic [plle_pkg::FCOUNT_W-1:0]   free_count;

  modport source (output valid, status, found_slot, found_data, free_count, input ready);
  modport sink   (input valid, status, found_slot, found_data, free_count, output ready);
endinterface

### hdl/pool_linked_list_engine.sv
// Pool linked list engine: one singly linked list of (id, data) records kept in a
// fixed slot pool, free slots on a LIFO stack. Operations arrive on in_ch, one result
// item per operation leaves on out_ch.
// Usage:
//   in_ch  carries mode (append, search, delete, clear), item_id and item_data.
//          in_ch.ready is high while the sequencer is idle; one operation at a time.
//   out_ch carries status, found_slot, found_data and free_count from an output
//          register; the next operation is taken while a result still waits there.
// Walk: the list is walked one node per cycle through the link memory read port.
//   Sequence from the accepting cycle to the result: pool full, or search/delete/clear
//   on an empty list, go straight to done; append pops the free stack, then walks to
//   the tail unless the list was empty; search walks to the first hit or the end;
//   delete walks to the first hit or the end and frees a hit node; clear walks the list.
//   in_ch.ready rises again in the cycle after the result is loaded into the output
//   register.
// Reset (rst_n low, synchronous): empty list, free stack holds every slot with the
//   highest on top, output empty. Link entries carry valid bits, so no clearing pass.
// Receiver stall: the result stays in the output register; a finished operation
//   behind it waits in its last state, and no further item is accepted meanwhile.
// Depends on plle_pkg, plle_ifs and pool_linked_list_engine_defines.svh.

`include "pool_linked_list_engine_defines.svh"

module pool_linked_list_engine #(
  parameter int POOL_SLOTS = plle_pkg::POOL_SLOTS_DEF,
  parameter int DATA_WIDTH = plle_pkg::DATA_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  plle_in_if.sink    in_ch,
  plle_out_if.source out_ch
);

  // widths derived from the pool size
  localparam int IW         = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int SW         = $clog2(POOL_SLOTS + 1);
  localparam int STORE_W    = (DATA_WIDTH < plle_pkg::DATA_IN_W) ? DATA_WIDTH
                                                                  : plle_pkg::DATA_IN_W;
  localparam int ID_W       = plle_pkg::ID_W;
  localparam int REC_W      = ID_W + STORE_W;
  localparam int SLOT_OUT_W = plle_pkg::SLOT_OUT_W;
  localparam int FDATA_W    = plle_pkg::FDATA_W;
  localparam int FCOUNT_W   = plle_pkg::FCOUNT_W;

  localparam logic [SW-1:0] NIL    = SW'(POOL_SLOTS);
  localparam logic [SW-1:0] ONE_S  = SW'(1);
  localparam logic [SW-1:0] TOP_RS = SW'(POOL_SLOTS - 1);

  // control registers
  plle_pkg::state_t state_r, state_nxt;
  logic [SW-1:0]    head_r, head_nxt;
  logic [SW-1:0]    free_top_r, free_top_nxt;
  logic [SW-1:0]    free_cnt_r, free_cnt_nxt;
  logic [POOL_SLOTS-1:0] link_vld_r;
  logic             out_valid_r;

  // operation registers
  plle_pkg::mode_t  mode_r, mode_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;
  logic [STORE_W-1:0] data_r, data_nxt;
  logic [SW-1:0]    cur_r, cur_nxt;
  logic [SW-1:0]    prev_r, prev_nxt;
  logic [SW-1:0]    new_r, new_nxt;
  plle_pkg::status_t res_status_r, res_status_nxt;
  logic [IW-1:0]    res_slot_r, res_slot_nxt;
  logic [STORE_W-1:0] res_data_r, res_data_nxt;

  // output registers
  plle_pkg::status_t  out_status_r;
  logic [IW-1:0]      out_slot_r;
  logic [STORE_W-1:0] out_data_r;
  logic [SW-1:0]      out_cnt_r;

  // memories and their ports
  logic [SW-1:0]    link_mem [POOL_SLOTS];
  logic [REC_W-1:0] rec_mem  [POOL_SLOTS];
  logic             rd_en;
  logic [IW-1:0]    rd_addr;
  logic [IW-1:0]    rd_addr_q;
  logic [SW-1:0]    link_q;
  logic             link_vld_q;
  logic [REC_W-1:0] rec_q;
  logic             lnk_we;
  logic [IW-1:0]    lnk_waddr;
  logic [SW-1:0]    lnk_wdata;
  logic             rec_we;

  // decoded conditions
  logic             in_fire;
  logic             out_load;
  logic [SW-1:0]    link_rd;
  logic             walk_nil;
  logic             walk_hit;
  logic             head_nil;
  logic             pool_empty;
  plle_pkg::mode_t  in_mode;

  assign in_fire    = in_ch.valid && in_ch.ready;
  assign in_mode    = plle_pkg::mode_t'(in_ch.mode);
  assign out_load   = (state_r == plle_pkg::S_DONE) && (!out_valid_r || out_ch.ready);
  assign head_nil   = (head_r >= NIL);
  assign pool_empty = (free_cnt_r == '0);

  // link read data, an entry never written reads as its reset link
  always_comb begin
    if (link_vld_q) begin
      link_rd = link_q;
    end else if (rd_addr_q == '0) begin
      link_rd = NIL;
    end else begin
      link_rd = SW'(rd_addr_q) - ONE_S;
    end
  end

  assign walk_nil = (link_rd >= NIL);
  assign walk_hit = (rec_q[STORE_W +: ID_W] == id_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      plle_pkg::S_IDLE: begin
        if (in_fire) begin
          if (in_mode == plle_pkg::MODE_APPEND) begin
            state_nxt = pool_empty ? plle_pkg::S_DONE : plle_pkg::S_POP;
          end else begin
            state_nxt = head_nil ? plle_pkg::S_DONE : plle_pkg::S_WALK;
          end
        end
      end
      plle_pkg::S_POP: begin
        state_nxt = head_nil ? plle_pkg::S_DONE : plle_pkg::S_WALK;
      end
      plle_pkg::S_WALK: begin
        case (mode_r)
          plle_pkg::MODE_SEARCH: begin
            if (walk_hit || walk_nil) state_nxt = plle_pkg::S_DONE;
          end
          plle_pkg::MODE_DELETE: begin
            if (walk_hit) begin
              state_nxt = plle_pkg::S_FREE;
            end else if (walk_nil) begin
              state_nxt = plle_pkg::S_DONE;
            end
          end
          default: begin
            if (walk_nil) state_nxt = plle_pkg::S_DONE;
          end
        endcase
      end
      plle_pkg::S_FREE: begin
        state_nxt = plle_pkg::S_DONE;
      end
      plle_pkg::S_DONE: begin
        if (out_load) state_nxt = plle_pkg::S_IDLE;
      end
      default: begin
        state_nxt = plle_pkg::S_IDLE;
      end
    endcase
  end

  // datapath and memory ports per state
  always_comb begin
    head_nxt       = head_r;
    free_top_nxt   = free_top_r;
    free_cnt_nxt   = free_cnt_r;
    mode_nxt       = mode_r;
    id_nxt         = id_r;
    data_nxt       = data_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    new_nxt        = new_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_data_nxt   = res_data_r;
    rd_en          = 1'b0;
    rd_addr        = cur_r[IW-1:0];
    lnk_we         = 1'b0;
    lnk_waddr      = cur_r[IW-1:0];
    lnk_wdata      = NIL;
    rec_we         = 1'b0;

    case (state_r)
      // take the item and start the first read
      plle_pkg::S_IDLE: begin
        if (in_fire) begin
          mode_nxt     = in_mode;
          id_nxt       = in_ch.item_id;
          data_nxt     = in_ch.item_data[STORE_W-1:0];
          prev_nxt     = NIL;
          cur_nxt      = head_r;
          res_slot_nxt = '0;
          res_data_nxt = '0;
          if (in_mode == plle_pkg::MODE_APPEND) begin
            res_status_nxt = pool_empty ? plle_pkg::STAT_FULL : plle_pkg::STAT_OK;
            rd_en          = !pool_empty;
            rd_addr        = free_top_r[IW-1:0];
          end else begin
            res_status_nxt = (in_mode == plle_pkg::MODE_CLEAR) ? plle_pkg::STAT_OK
                                                                : plle_pkg::STAT_NOT_FOUND;
            rd_en          = !head_nil;
            rd_addr        = head_r[IW-1:0];
          end
        end
      end
      // pop the free stack and write the new record
      plle_pkg::S_POP: begin
        new_nxt      = free_top_r;
        free_top_nxt = link_rd;
        free_cnt_nxt = free_cnt_r - ONE_S;
        lnk_we       = 1'b1;
        lnk_waddr    = free_top_r[IW-1:0];
        lnk_wdata    = NIL;
        rec_we       = 1'b1;
        res_slot_nxt = free_top_r[IW-1:0];
        if (head_nil) begin
          head_nxt = free_top_r;
        end else begin
          cur_nxt = head_r;
          rd_en   = 1'b1;
          rd_addr = head_r[IW-1:0];
        end
      end
      // one node per cycle
      plle_pkg::S_WALK: begin
        case (mode_r)
          plle_pkg::MODE_APPEND: begin
            if (walk_nil) begin
              lnk_we    = 1'b1;
              lnk_wdata = new_r;
            end else begin
              cur_nxt = link_rd;
              rd_en   = 1'b1;
              rd_addr = link_rd[IW-1:0];
            end
          end
          plle_pkg::MODE_SEARCH: begin
            if (walk_hit) begin
              res_status_nxt = plle_pkg::STAT_OK;
              res_slot_nxt   = cur_r[IW-1:0];
              res_data_nxt   = rec_q[STORE_W-1:0];
            end else if (!walk_nil) begin
              cur_nxt = link_rd;
              rd_en   = 1'b1;
              rd_addr = link_rd[IW-1:0];
            end
          end
          plle_pkg::MODE_DELETE: begin
            if (walk_hit) begin
              if (prev_r >= NIL) begin
                head_nxt       = link_rd;
                res_status_nxt = plle_pkg::STAT_DEL_HEAD;
              end else begin
                lnk_we         = 1'b1;
                lnk_waddr      = prev_r[IW-1:0];
                lnk_wdata      = link_rd;
                res_status_nxt = walk_nil ? plle_pkg::STAT_DEL_TAIL
                                          : plle_pkg::STAT_DEL_MID;
              end
            end else if (!walk_nil) begin
              prev_nxt = cur_r;
              cur_nxt  = link_rd;
              rd_en    = 1'b1;
              rd_addr  = link_rd[IW-1:0];
            end
          end
          default: begin
            // clear: push each node in list order
            lnk_we       = 1'b1;
            lnk_wdata    = free_top_r;
            free_top_nxt = cur_r;
            free_cnt_nxt = free_cnt_r + ONE_S;
            if (walk_nil) begin
              head_nxt = NIL;
            end else begin
              cur_nxt = link_rd;
              rd_en   = 1'b1;
              rd_addr = link_rd[IW-1:0];
            end
          end
        endcase
      end
      // push the unlinked node
      plle_pkg::S_FREE: begin
        lnk_we       = 1'b1;
        lnk_wdata    = free_top_r;
        free_top_nxt = cur_r;
        free_cnt_nxt = free_cnt_r + ONE_S;
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= plle_pkg::S_IDLE;
      head_r     <= NIL;
      free_top_r <= TOP_RS;
      free_cnt_r <= NIL;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      free_top_r <= free_top_nxt;
      free_cnt_r <= free_cnt_nxt;
    end
  end

  // link entries written since reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_vld_r <= '0;
    end else if (lnk_we) begin
      link_vld_r[lnk_waddr] <= 1'b1;
    end
  end

  // operation registers
  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    id_r         <= id_nxt;
    data_r       <= data_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    new_r        <= new_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_data_r   <= res_data_nxt;
  end

  // link memory
  always_ff @(posedge clk) begin
    if (lnk_we) begin
      link_mem[lnk_waddr] <= lnk_wdata;
    end
    if (rd_en) begin
      link_q     <= link_mem[rd_addr];
      link_vld_q <= link_vld_r[rd_addr];
      rd_addr_q  <= rd_addr;
    end
  end

  // record memory, id over data
  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[free_top_r[IW-1:0]] <= {id_r, data_r};
    end
    if (rd_en) begin
      rec_q <= rec_mem[rd_addr];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_data_r   <= res_data_r;
      out_cnt_r    <= free_cnt_r;
    end
  end

  // channel ports
  assign in_ch.ready       = (state_r == plle_pkg::S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.found_slot = SLOT_OUT_W'(out_slot_r);
  assign out_ch.found_data = FDATA_W'(out_data_r);
  assign out_ch.free_count = FCOUNT_W'(out_cnt_r);

  // checks
  `PLLE_ASSERT(a_free_cnt_range, free_cnt_r <= NIL, "free count above pool size")
  `PLLE_ASSERT(a_no_rw_same_link, !(rd_en && lnk_we && (rd_addr == lnk_waddr)), "link read and write collide")
  `PLLE_ASSERT_IMPL(a_idle_consistent, state_r == plle_pkg::S_IDLE, (head_r >= NIL) == (free_cnt_r == NIL), "empty list and full free stack disagree")
  `PLLE_ASSERT_IMPL(a_result_from_done, $rose(out_valid_r), $past(state_r == plle_pkg::S_DONE), "result valid without finished operation")

endmodule

### test/pool_linked_list_engine_test.sv
// pool_linked_list_engine_test.sv: self-checking bench for the pool linked list engine
// drives operation items, predicts list and free stack contents, checks every result item
// depends on plle_pkg, plle_ifs and the pool_linked_list_engine rtl

module pool_linked_list_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS        = plle_pkg::POOL_SLOTS_DEF;
  localparam int NIL          = SLOTS;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 950;
  localparam int KEY_COUNT    = 8;
  localparam int ID_W         = plle_pkg::ID_W;
  localparam int DATA_IN_W    = plle_pkg::DATA_IN_W;
  localparam int SLOT_OUT_W   = plle_pkg::SLOT_OUT_W;
  localparam int FDATA_W      = plle_pkg::FDATA_W;
  localparam int FCOUNT_W     = plle_pkg::FCOUNT_W;

  typedef plle_pkg::mode_t   mode_t;
  typedef plle_pkg::status_t status_t;

  typedef struct packed {
    status_t                status;
    logic [SLOT_OUT_W-1:0]  slot;
    logic [FDATA_W-1:0]     data;
    logic [FCOUNT_W-1:0]    free_cnt;
  } op_result_t;

  // shadow of the slot pool plus the queue of results still owed by the engine
  class list_pool_tracker;
    int unsigned          link_mem[SLOTS];
    logic [ID_W-1:0]      id_mem[SLOTS];
    logic [DATA_IN_W-1:0] data_mem[SLOTS];
    int unsigned          head;
    int unsigned          free_top;
    int unsigned          free_cnt;
    op_result_t           pending_results[$];
    int unsigned          errors;
    int unsigned          mode_seen[4];
    int unsigned          status_seen[6];

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        link_mem[i] = (i == 0) ? NIL : i - 1;
        id_mem[i]   = '0;
        data_mem[i] = '0;
      end
      head     = NIL;
      free_top = NIL - 1;
      free_cnt = SLOTS;
      errors   = 0;
    endfunction

    function void push_free(int unsigned s);
      link_mem[s] = free_top;
      free_top    = s;
      free_cnt++;
    endfunction

    // id held by a random node of the list, or any id when the list is empty
    function logic [ID_W-1:0] pick_list_id();
      int unsigned cur;
      int unsigned pos;
      if (head >= NIL) return ID_W'($urandom);
      pos = $urandom_range(0, SLOTS - free_cnt - 1);
      cur = head;
      repeat (pos) if (link_mem[cur] < NIL) cur = link_mem[cur];
      return id_mem[cur];
    endfunction

    // apply one accepted operation and queue the result it must produce
    function void note_op(mode_t m, logic [ID_W-1:0] id, logic [DATA_IN_W-1:0] d);
      op_result_t  r;
      int unsigned cur;
      int unsigned prv;
      int unsigned n;
      int unsigned nx;
      int unsigned steps;
      r = '0;
      r.status = plle_pkg::STAT_OK;
      case (m)
        plle_pkg::MODE_APPEND: begin
          if (free_top >= NIL || free_cnt == 0) begin
            r.status = plle_pkg::STAT_FULL;
          end else begin
            n           = free_top;
            free_top    = link_mem[n];
            free_cnt--;
            id_mem[n]   = id;
            data_mem[n] = d;
            link_mem[n] = NIL;
            if (head >= NIL) begin
              head = n;
            end else begin
              // walk to the tail and hook the new node on
              cur   = head;
              steps = 0;
              while (steps < NIL && link_mem[cur] < NIL) begin
                cur = link_mem[cur];
                steps++;
              end
              link_mem[cur] = n;
            end
            r.slot = SLOT_OUT_W'(n);
          end
        end
        plle_pkg::MODE_SEARCH: begin
          r.status = plle_pkg::STAT_NOT_FOUND;
          cur      = head;
          steps    = 0;
          while (steps < NIL && cur < NIL) begin
            if (id_mem[cur] == id) begin
              r.status = plle_pkg::STAT_OK;
              r.slot   = SLOT_OUT_W'(cur);
              r.data   = data_mem[cur];
              break;
            end
            cur = link_mem[cur];
            steps++;
          end
        end
        plle_pkg::MODE_DELETE: begin
          r.status = plle_pkg::STAT_NOT_FOUND;
          cur      = head;
          prv      = NIL;
          steps    = 0;
          while (steps < NIL && cur < NIL && id_mem[cur] != id) begin
            prv = cur;
            cur = link_mem[cur];
            steps++;
          end
          if (cur < NIL && id_mem[cur] == id) begin
            nx = link_mem[cur];
            if (prv >= NIL) begin
              head     = nx;
              r.status = plle_pkg::STAT_DEL_HEAD;
            end else begin
              link_mem[prv] = nx;
              r.status      = (nx >= NIL) ? plle_pkg::STAT_DEL_TAIL
                                          : plle_pkg::STAT_DEL_MID;
            end
            push_free(cur);
          end
        end
        default: begin
          // nodes go back on the free stack in list order
          cur   = head;
          steps = 0;
          while (steps < NIL && cur < NIL) begin
            nx = link_mem[cur];
            push_free(cur);
            cur = nx;
            steps++;
          end
          head = NIL;
        end
      endcase
      r.free_cnt = FCOUNT_W'(free_cnt);
      mode_seen[m]++;
      status_seen[r.status]++;
      pending_results.push_back(r);
    endfunction

    // compare one result item against the oldest outstanding one
    function void check_result(op_result_t got);
      op_result_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result item: status %0d slot %0d data %h free %0d",
               got.status, got.slot, got.data, got.free_cnt);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.slot !== want.slot) begin
        $error("found_slot mismatch: expected %0d, actual %0d", want.slot, got.slot);
        errors++;
      end
      if (got.data !== want.data) begin
        $error("found_data mismatch: expected %h, actual %h", want.data, got.data);
        errors++;
      end
      if (got.free_cnt !== want.free_cnt) begin
        $error("free_count mismatch: expected %0d, actual %0d", want.free_cnt, got.free_cnt);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  plle_in_if  in_ch();
  plle_out_if out_ch();

  pool_linked_list_engine i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  list_pool_tracker pool_sb;
  bit               quiet_phase = 1'b0;
  int unsigned      items_sent  = 0;
  int unsigned      idle_cycles = 0;
  logic [ID_W-1:0]  key_ids[KEY_COUNT];

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
               idle_cycles, pool_sb.pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one operation item, with a random gap ahead of it unless the phase is quiet
  task automatic send_op(mode_t m, logic [ID_W-1:0] id, logic [DATA_IN_W-1:0] d);
    int unsigned gap;
    gap = quiet_phase ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= m;
    in_ch.item_id   <= id;
    in_ch.item_data <= d;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pool_sb.note_op(m, id, d);
    items_sent++;
    @(negedge clk);
  endtask

  // ids mostly hit the list or a small key set so that searches and deletes match
  function automatic logic [ID_W-1:0] choose_id();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return pool_sb.pick_list_id();
    if (r < 8) return key_ids[$urandom_range(0, KEY_COUNT - 1)];
    return ID_W'($urandom);
  endfunction

  task automatic random_op();
    int unsigned r;
    mode_t       m;
    r = $urandom_range(0, 99);
    if (r < 45)      m = plle_pkg::MODE_APPEND;
    else if (r < 70) m = plle_pkg::MODE_SEARCH;
    else if (r < 97) m = plle_pkg::MODE_DELETE;
    else             m = plle_pkg::MODE_CLEAR;
    send_op(m, choose_id(), $urandom);
  endtask

  // result side: random stall before each item, none in quiet phases
  initial begin : result_sink
    int unsigned stall;
    op_result_t  got;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = quiet_phase ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      got.status   = status_t'(out_ch.status);
      got.slot     = out_ch.found_slot;
      got.data     = out_ch.found_data;
      got.free_cnt = out_ch.free_count;
      pool_sb.check_result(got);
      @(negedge clk);
    end
  end

  // stimulus and end of run
  initial begin : stimulus
    int unsigned target;
    int unsigned kind;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.mode      = plle_pkg::MODE_APPEND;
    in_ch.item_id   = '0;
    in_ch.item_data = '0;
    pool_sb         = new();
    foreach (key_ids[k]) key_ids[k] = ID_W'($urandom);
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // empty list corner cases
    send_op(plle_pkg::MODE_SEARCH, 16'h0000, 32'h0000_0000);
    send_op(plle_pkg::MODE_DELETE, 16'h0000, 32'hFFFF_FFFF);
    send_op(plle_pkg::MODE_CLEAR,  16'hFFFF, 32'h0000_0000);
    // single node: delete is both head and tail
    send_op(plle_pkg::MODE_APPEND, 16'h0000, 32'h0000_0000);
    send_op(plle_pkg::MODE_DELETE, 16'h0000, 32'h0000_0000);
    // build FFFF, 1234, 00FF, 1234 with extreme payloads and a duplicate id
    send_op(plle_pkg::MODE_APPEND, 16'hFFFF, 32'hFFFF_FFFF);
    send_op(plle_pkg::MODE_APPEND, 16'h1234, 32'hA5A5_A5A5);
    send_op(plle_pkg::MODE_APPEND, 16'h00FF, 32'h5A5A_5A5A);
    send_op(plle_pkg::MODE_APPEND, 16'h1234, 32'h0000_FFFF);
    send_op(plle_pkg::MODE_SEARCH, 16'h1234, 32'h0000_0000);
    send_op(plle_pkg::MODE_SEARCH, 16'hFFFF, 32'h0000_0000);
    send_op(plle_pkg::MODE_SEARCH, 16'hBEEF, 32'h0000_0000);
    // middle, middle, tail, then misses on a populated list
    send_op(plle_pkg::MODE_DELETE, 16'h00FF, 32'h0000_0000);
    send_op(plle_pkg::MODE_DELETE, 16'h1234, 32'h0000_0000);
    send_op(plle_pkg::MODE_DELETE, 16'h1234, 32'h0000_0000);
    send_op(plle_pkg::MODE_SEARCH, 16'h1234, 32'h0000_0000);
    send_op(plle_pkg::MODE_DELETE, 16'h7777, 32'h0000_0000);
    // head delete with a successor, then clears of one and of two nodes
    send_op(plle_pkg::MODE_APPEND, 16'h8000, 32'h8000_0000);
    send_op(plle_pkg::MODE_DELETE, 16'hFFFF, 32'h0000_0000);
    send_op(plle_pkg::MODE_CLEAR,  16'h0000, 32'h0000_0000);
    send_op(plle_pkg::MODE_APPEND, 16'h0001, 32'h0000_0001);
    send_op(plle_pkg::MODE_APPEND, 16'h0002, 32'h0000_0002);
    send_op(plle_pkg::MODE_CLEAR,  16'h0000, 32'h0000_0000);

    // random phases: mixed traffic, fills past full, drains by present ids
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      quiet_phase = ($urandom_range(0, 3) == 0);
      kind        = $urandom_range(0, 9);
      if (kind < 2) begin
        repeat (pool_sb.free_cnt + $urandom_range(1, 3))
          send_op(plle_pkg::MODE_APPEND, choose_id(), $urandom);
      end else if (kind < 3) begin
        repeat ($urandom_range(5, 20))
          send_op(plle_pkg::MODE_DELETE, pool_sb.pick_list_id(), $urandom);
      end else begin
        repeat ($urandom_range(20, 60)) random_op();
      end
    end
    in_ch.valid <= 1'b0;

    // let outstanding results arrive, then watch for stray ones
    while (pool_sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d operations: %0d appends (%0d refused full), %0d searches,",
             items_sent, pool_sb.mode_seen[plle_pkg::MODE_APPEND],
             pool_sb.status_seen[plle_pkg::STAT_FULL], pool_sb.mode_seen[plle_pkg::MODE_SEARCH]);
    $display("%0d deletes (%0d heads, %0d tails, %0d middles), %0d clears, %0d not-found, %0d mismatches",
             pool_sb.mode_seen[plle_pkg::MODE_DELETE], pool_sb.status_seen[plle_pkg::STAT_DEL_HEAD],
             pool_sb.status_seen[plle_pkg::STAT_DEL_TAIL], pool_sb.status_seen[plle_pkg::STAT_DEL_MID],
             pool_sb.mode_seen[plle_pkg::MODE_CLEAR], pool_sb.status_seen[plle_pkg::STAT_NOT_FOUND],
             pool_sb.errors);
    if (pool_sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/plle_pkg.sv
hdl/plle_ifs.sv
hdl/pool_linked_list_engine.sv
test/pool_linked_list_engine_test.sv
